>>> src/kse_pkg.sv
package kse_pkg;

    localparam int MaxRowsHw  = 5;
    localparam int MaxColsHw  = 4;
    localparam int NumRowsDef = 5;
    localparam int NumColsDef = 4;

    localparam int ColW      = 4;
    localparam int UnstableW = 5;
    localparam int TickW     = 32;
    localparam int KeyW      = 5;
    localparam int EventW    = 3;

    // input request packing, lowest bit first
    localparam int InPttLo      = 0;
    localparam int InSideLo     = 1;
    localparam int InRow1Lo     = 5;
    localparam int InRow2Lo     = 9;
    localparam int InRow3Lo     = 13;
    localparam int InRow4Lo     = 17;
    localparam int InUnstableLo = 21;
    localparam int InTickLo     = 26;
    localparam int InDataW      = 64;
    localparam int OutDataW     = 8;

    localparam logic [KeyW-1:0] KeyNone = 5'd19;
    localparam logic [KeyW-1:0] KeyUp   = 5'd6;
    localparam logic [KeyW-1:0] KeyDown = 5'd10;
    localparam logic [KeyW-1:0] KeyF    = 5'd17;
    localparam logic [KeyW-1:0] KeyPtt  = 5'd18;

    localparam logic [TickW-1:0] LongTicksRst = 32'd500;

    typedef enum logic [EventW-1:0] {
        EV_PRESSED   = 3'd0,
        EV_PRESSED_F = 3'd1,
        EV_LONG      = 3'd2,
        EV_LONG_CONT = 3'd3,
        EV_RELEASED  = 3'd4
    } t_key_event;

    // column pin sampled and key found at each matrix position
    localparam logic [1:0] RowPin [MaxRowsHw][MaxColsHw] = '{
        '{2'd0, 2'd1, 2'd1, 2'd1},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3}
    };
    localparam logic [KeyW-1:0] RowKey [MaxRowsHw][MaxColsHw] = '{
        '{5'd0,  5'd1,  5'd19, 5'd19},
        '{5'd2,  5'd3,  5'd4,  5'd5},
        '{5'd6,  5'd7,  5'd8,  5'd9},
        '{5'd10, 5'd11, 5'd12, 5'd13},
        '{5'd14, 5'd15, 5'd16, 5'd17}
    };

    // up to two events caused by one poll, slot 0 goes out first
    typedef struct packed {
        logic [1:0]      cnt;
        logic [KeyW-1:0] code0;
        t_key_event      ev0;
        logic [KeyW-1:0] code1;
        t_key_event      ev1;
    } t_result;

endpackage

>>> src/kse_scan.sv
module kse_scan
    import kse_pkg::*;
#(
    parameter int NUM_ROWS = NumRowsDef,
    parameter int NUM_COLS = NumColsDef
) (
    input  logic [MaxRowsHw-1:0][ColW-1:0] i_row_cols,
    input  logic [UnstableW-1:0]           i_unstable,
    output logic [KeyW-1:0]                o_key
);

    localparam int RowsEff = (NUM_ROWS < MaxRowsHw) ? NUM_ROWS : MaxRowsHw;
    localparam int ColsEff = (NUM_COLS < MaxColsHw) ? NUM_COLS : MaxColsHw;

    always_comb begin
        logic stop;
        logic col_done;
        o_key    = KeyNone;
        stop     = 1'b0;
        col_done = 1'b0;
        for (int i = 0; i < RowsEff; i++) begin
            if (!stop) begin
                if (i_unstable[i]) begin
                    stop = 1'b1;
                end else begin
                    col_done = 1'b0;
                    for (int j = 0; j < ColsEff; j++) begin
                        if (!col_done && !i_row_cols[i][RowPin[i][j]]) begin
                            o_key    = RowKey[i][j];
                            col_done = 1'b1;
                        end
                    end
                    if (o_key != KeyNone) begin
                        stop = 1'b1;
                    end
                end
            end
        end
    end

endmodule

>>> src/kse_core.sv
module kse_core
    import kse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_move,
    input  logic             i_ptt,
    input  logic [KeyW-1:0]  i_scan_key,
    input  logic [TickW-1:0] i_now,
    input  logic             i_cfg_we,
    input  logic [TickW-1:0] i_cfg_wdata,
    output t_result          o_res
);

    logic             r_ptt_was, n_ptt_was;
    logic [KeyW-1:0]  r_cur_key, n_cur_key;
    t_key_event       r_phase, n_phase;
    logic [KeyW-1:0]  r_rep_key, n_rep_key;
    logic [TickW-1:0] r_start, n_start;
    logic             r_f_armed, n_f_armed;
    logic [TickW-1:0] r_long_ticks;

    always_comb begin
        logic [TickW-1:0] elapsed;
        logic             ptt_hit;
        t_key_event       ptt_ev;
        logic             key_hit;
        logic [KeyW-1:0]  key_code;
        t_key_event       key_ev;

        n_ptt_was = r_ptt_was;
        n_cur_key = r_cur_key;
        n_phase   = r_phase;
        n_rep_key = r_rep_key;
        n_start   = r_start;
        n_f_armed = r_f_armed;
        ptt_hit   = 1'b0;
        ptt_ev    = EV_PRESSED;
        key_hit   = 1'b0;
        key_code  = r_rep_key;
        key_ev    = EV_RELEASED;
        elapsed   = i_now - r_start;

        if (r_ptt_was && !i_ptt) begin
            ptt_hit   = 1'b1;
            ptt_ev    = EV_RELEASED;
            n_ptt_was = 1'b0;
        end else if (!r_ptt_was && i_ptt) begin
            ptt_hit   = 1'b1;
            ptt_ev    = EV_PRESSED;
            n_ptt_was = 1'b1;
        end else if (!r_ptt_was && !i_ptt) begin
            n_cur_key = i_scan_key;
        end

        if (n_cur_key != KeyNone) begin
            case (r_phase)
                EV_RELEASED: begin
                    key_hit  = 1'b1;
                    key_code = n_cur_key;
                    if (r_f_armed) begin
                        key_ev    = EV_PRESSED_F;
                        n_phase   = EV_PRESSED_F;
                        n_f_armed = 1'b0;
                    end else begin
                        key_ev  = EV_PRESSED;
                        n_phase = EV_PRESSED;
                    end
                    if (n_cur_key == KeyF) begin
                        n_f_armed = 1'b1;
                    end
                    n_start   = i_now;
                    n_rep_key = n_cur_key;
                end
                EV_PRESSED: begin
                    if (elapsed >= r_long_ticks) begin
                        n_start = '0;
                        n_phase = EV_LONG;
                    end
                end
                EV_LONG, EV_LONG_CONT: begin
                    key_hit  = 1'b1;
                    key_code = n_cur_key;
                    key_ev   = r_phase;
                    n_phase  = EV_LONG_CONT;
                end
                default: begin
                end
            endcase
        end else if (r_phase != EV_RELEASED) begin
            // release is held back after F-shifted or long presses,
            // except up/down after repeats
            if (r_phase == EV_PRESSED) begin
                key_hit = 1'b1;
            end
            if (r_phase == EV_LONG_CONT && (r_rep_key == KeyUp || r_rep_key == KeyDown)) begin
                key_hit = 1'b1;
            end
            key_code  = r_rep_key;
            key_ev    = EV_RELEASED;
            n_start   = '0;
            n_phase   = EV_RELEASED;
            n_rep_key = KeyNone;
        end

        o_res.code1 = key_code;
        o_res.ev1   = key_ev;
        if (ptt_hit) begin
            o_res.cnt   = key_hit ? 2'd2 : 2'd1;
            o_res.code0 = KeyPtt;
            o_res.ev0   = ptt_ev;
        end else begin
            o_res.cnt   = key_hit ? 2'd1 : 2'd0;
            o_res.code0 = key_code;
            o_res.ev0   = key_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptt_was    <= 1'b0;
            r_cur_key    <= KeyNone;
            r_phase      <= EV_RELEASED;
            r_rep_key    <= KeyNone;
            r_start      <= '0;
            r_f_armed    <= 1'b0;
            r_long_ticks <= LongTicksRst;
        end else begin
            if (i_cfg_we) begin
                r_long_ticks <= i_cfg_wdata;
            end
            if (i_move) begin
                r_ptt_was <= n_ptt_was;
                r_cur_key <= n_cur_key;
                r_phase   <= n_phase;
                r_rep_key <= n_rep_key;
                r_start   <= n_start;
                r_f_armed <= n_f_armed;
            end
        end
    end

endmodule

>>> src/kse_out.sv
module kse_out
    import kse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_res,
    input  logic                i_tready,
    output logic                o_tvalid,
    output logic [OutDataW-1:0] o_tdata,
    output logic                o_tlast,
    output logic                o_free
);

    logic    r_valid;
    logic    r_sel;
    t_result r_res;
    logic    fire;
    logic    last;

    assign last     = r_sel || (r_res.cnt == 2'd1);
    assign fire     = r_valid && i_tready;
    assign o_free   = !r_valid || (fire && last);
    assign o_tvalid = r_valid;
    assign o_tlast  = last;
    assign o_tdata  = r_sel ? {r_res.ev1, r_res.code1} : {r_res.ev0, r_res.code0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> src/keypad_scan_event_generator.sv
// channel    dir  signals                          request
// ---------  ---  -------------------------------  ------------------------------------
// poll in    in   i_s_axis_tvalid/o_tready/tdata   one keypad poll
// event out  out  o_m_axis_tvalid/i_tready/tdata   one key event, tlast = last of poll
// config     in   i_cfg_we/i_cfg_wdata             long_press_ticks, written on i_cfg_we
//
// A poll is registered, then scanned and run through the key state machine
// combinationally; its one or two events, if any, load the output register together.
// Polls are taken every cycle unless a poll with events finds the output still busy.
// Reset (synchronous, active low) clears the key state and sets long_press_ticks to 500.
// A stall on the output holds a poll with events, which then backs up the input.
module keypad_scan_event_generator
    import kse_pkg::*;
#(
    parameter int NUM_ROWS = NumRowsDef,
    parameter int NUM_COLS = NumColsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // ptt_pressed, side_cols, row1_cols, row2_cols, row3_cols, row4_cols,
    // unstable_rows, now_tick, zero fill
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // key_code, key_event
    output logic [OutDataW-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tvalid,
    output logic                o_m_axis_tlast,
    input  logic                i_m_axis_tready,
    input  logic                i_cfg_we,
    input  logic [TickW-1:0]    i_cfg_wdata
);

    logic                          r_in_valid;
    logic [InDataW-1:0]            r_in_data;
    logic                          move;
    logic                          out_free;
    logic [MaxRowsHw-1:0][ColW-1:0] row_cols;
    logic [KeyW-1:0]               scan_key;
    t_result                       res;

    assign row_cols = {r_in_data[InRow4Lo +: ColW], r_in_data[InRow3Lo +: ColW],
                       r_in_data[InRow2Lo +: ColW], r_in_data[InRow1Lo +: ColW],
                       r_in_data[InSideLo +: ColW]};

    // a poll with no events never waits on the output
    assign move            = r_in_valid && (res.cnt == 2'd0 || out_free);
    assign o_s_axis_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    kse_scan #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_scan (
        .i_row_cols (row_cols),
        .i_unstable (r_in_data[InUnstableLo +: UnstableW]),
        .o_key      (scan_key)
    );

    kse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_move      (move),
        .i_ptt       (r_in_data[InPttLo]),
        .i_scan_key  (scan_key),
        .i_now       (r_in_data[InTickLo +: TickW]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res)
    );

    kse_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move && res.cnt != 2'd0),
        .i_res    (res),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_free   (out_free)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import kse_pkg::*;
;

    localparam int Limit      = 1_000_000;
    localparam int PhaseItems = 150;
    localparam int SinkHold   = 400;

    localparam logic [KeyW-1:0] KeySide1 = 5'd0;
    localparam logic [KeyW-1:0] KeySide2 = 5'd1;
    localparam logic [KeyW-1:0] KeyMenu  = 5'd2;
    localparam logic [KeyW-1:0] KeyFive  = 5'd8;
    localparam logic [KeyW-1:0] KeyStar  = 5'd15;

    // one poll request, laid out exactly as i_s_axis_tdata
    typedef struct packed {
        logic [5:0]       fill;
        logic [TickW-1:0] tick;
        logic [4:0]       unstable;
        logic [4:0][3:0]  cols;      // [0] side row, [1..4] rows 1..4
        logic             ptt;
    } t_poll;

    class key_event_book;
        typedef struct {
            logic [KeyW-1:0] code;
            t_key_event      ev;
            logic            last;
        } t_key_ev;

        logic [TickW-1:0] long_ticks;
        logic             ptt_held;
        logic [KeyW-1:0]  cur_key;
        logic [KeyW-1:0]  held_key;
        t_key_event       phase;
        logic [TickW-1:0] start_tick;
        logic             f_armed;
        t_key_ev          events_due[$];
        int               errors;

        function new();
            long_ticks = LongTicksRst;
            ptt_held   = 1'b0;
            cur_key    = KeyNone;
            held_key   = KeyNone;
            phase      = EV_RELEASED;
            start_tick = '0;
            f_armed    = 1'b0;
            errors     = 0;
        endfunction

        // priority scan: side row first, lowest column first, stop at an unsettled row
        function logic [KeyW-1:0] scan(t_poll p);
            for (int r = 0; r < 5; r++) begin
                if (p.unstable[r])
                    return KeyNone;
                if (r == 0) begin
                    if (!p.cols[0][0])
                        return KeySide1;
                    if (!p.cols[0][1])
                        return KeySide2;
                end else begin
                    for (int c = 0; c < 4; c++)
                        if (!p.cols[r][c])
                            return KeyW'(KeyMenu + 4 * (r - 1) + c);
                end
            end
            return KeyNone;
        endfunction

        function void take_poll(t_poll p);
            t_key_ev          fresh[$];
            logic [TickW-1:0] elapsed;
            if (ptt_held && !p.ptt) begin
                fresh.push_back(t_key_ev'{KeyPtt, EV_RELEASED, 1'b0});
                ptt_held = 1'b0;
            end else if (!ptt_held && p.ptt) begin
                fresh.push_back(t_key_ev'{KeyPtt, EV_PRESSED, 1'b0});
                ptt_held = 1'b1;
            end else if (!ptt_held && !p.ptt) begin
                cur_key = scan(p);
            end

            if (cur_key != KeyNone) begin
                if (phase == EV_RELEASED) begin
                    if (f_armed) begin
                        fresh.push_back(t_key_ev'{cur_key, EV_PRESSED_F, 1'b0});
                        phase   = EV_PRESSED_F;
                        f_armed = 1'b0;
                    end else begin
                        fresh.push_back(t_key_ev'{cur_key, EV_PRESSED, 1'b0});
                        phase = EV_PRESSED;
                    end
                    if (cur_key == KeyF)
                        f_armed = 1'b1;
                    start_tick = p.tick;
                    held_key   = cur_key;
                end else if (phase == EV_PRESSED) begin
                    elapsed = p.tick - start_tick;
                    if (elapsed >= long_ticks) begin
                        start_tick = '0;
                        phase      = EV_LONG;
                    end
                end else if (phase == EV_LONG || phase == EV_LONG_CONT) begin
                    fresh.push_back(t_key_ev'{cur_key, phase, 1'b0});
                    phase = EV_LONG_CONT;
                end
            end else if (phase != EV_RELEASED) begin
                // release is dropped after F-shift or long press, except up/down repeats
                if (phase == EV_PRESSED)
                    fresh.push_back(t_key_ev'{held_key, EV_RELEASED, 1'b0});
                if (phase == EV_LONG_CONT && (held_key == KeyUp || held_key == KeyDown))
                    fresh.push_back(t_key_ev'{held_key, EV_RELEASED, 1'b0});
                start_tick = '0;
                phase      = EV_RELEASED;
                held_key   = KeyNone;
            end

            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                events_due.push_back(fresh[i]);
        endfunction

        function void match_event(logic [KeyW-1:0] code, logic [EventW-1:0] ev, logic last);
            t_key_ev want;
            if (events_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event: code %0d event %0d last %0b", code, ev, last);
                return;
            end
            want = events_due.pop_front();
            if (want.code !== code || want.ev !== ev || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display({"event mismatch: expected code %0d event %0d last %0b,",
                              " got %0d %0d %0b"},
                             want.code, want.ev, want.last, code, ev, last);
            end
        endfunction

        function int pending();
            return events_due.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic [InDataW-1:0]  i_s_axis_tdata;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                o_m_axis_tlast;
    logic                i_m_axis_tready;
    logic                i_cfg_we;
    logic [TickW-1:0]    i_cfg_wdata;

    key_event_book book = new();

    logic [TickW-1:0] now_t;
    int               cycles;
    int               sent;
    bit               hold_sink;
    int               hold_cnt;

    keypad_scan_event_generator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == Limit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            book.match_event(o_m_axis_tdata[KeyW-1:0], o_m_axis_tdata[KeyW +: EventW],
                             o_m_axis_tlast);
    end

    // event sink: random stalls, ready stretches, and one long hold-off on request
    initial begin
        int   stall;
        int   free;
        int   r;
        logic rdy;
        stall           = 0;
        free            = 0;
        hold_cnt        = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (hold_sink) begin
                hold_sink = 1'b0;
                hold_cnt  = SinkHold;
                rdy       = 1'b0;
            end else if (free > 0) begin
                free--;
                rdy = 1'b1;
            end else if (stall > 0) begin
                stall--;
                rdy = 1'b0;
            end else begin
                r   = $urandom_range(0, 199);
                rdy = 1'b1;
                if (r == 0) begin
                    free = 100;
                end else if (r < 50) begin
                    rdy   = 1'b0;
                    stall = (r < 45) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
            i_m_axis_tready <= rdy;
        end
    end

    function automatic int idle_gap();
        int r;
        if (hold_sink || hold_cnt > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TickW-1:0] next_tick();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            now_t = now_t + $urandom_range(0, 3);
        else if (r < 14)
            now_t = now_t + book.long_ticks + $urandom_range(0, 2) - 1;
        else if (r < 17)
            now_t = now_t + $urandom_range(0, 50);
        else if (r < 19)
            now_t = now_t + $urandom;
        else
            now_t = $urandom;
        return now_t;
    endfunction

    function automatic t_poll noise_poll();
        t_poll p;
        p      = {$urandom, $urandom};
        p.fill = '0;
        return p;
    endfunction

    // poll with one key as the first hit of the scan; later rows carry random bits
    function automatic t_poll key_poll(logic [KeyW-1:0] key, logic [TickW-1:0] t);
        t_poll p;
        int    k;
        int    r;
        int    c;
        p      = noise_poll();
        p.ptt  = 1'b0;
        p.tick = t;
        k      = key;
        if (key < KeyMenu) begin
            r = 0;
            c = k;
        end else begin
            r = (k - KeyMenu) / 4 + 1;
            c = (k - KeyMenu) % 4;
        end
        p.cols[0][1:0] = 2'b11;
        for (int rr = 1; rr < r; rr++)
            p.cols[rr] = 4'hf;
        for (int cc = 0; cc < c; cc++)
            p.cols[r][cc] = 1'b1;
        p.cols[r][c] = 1'b0;
        for (int rr = 0; rr <= r; rr++)
            p.unstable[rr] = 1'b0;
        return p;
    endfunction

    function automatic t_poll quiet_poll(logic [TickW-1:0] t);
        t_poll p;
        p              = noise_poll();
        p.ptt          = 1'b0;
        p.tick         = t;
        p.cols[0][1:0] = 2'b11;
        for (int rr = 1; rr < 5; rr++)
            p.cols[rr] = 4'hf;
        if ($urandom_range(0, 1))
            p.unstable = '0;
        return p;
    endfunction

    task automatic send(t_poll p);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        book.take_poll(p);
        sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_long_ticks(logic [TickW-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        book.long_ticks  = v;
    endtask

    // a key held over several polls, sometimes changing key or toggling PTT
    task automatic press_run();
        logic [KeyW-1:0] key;
        int              pick;
        logic            ptt_lvl;
        t_poll           p;
        pick    = $urandom_range(0, 9);
        key     = (pick == 0) ? KeyF : (pick == 1) ? KeyUp : (pick == 2) ? KeyDown :
                  KeyW'($urandom_range(KeySide1, KeyF));
        ptt_lvl = 1'b0;
        send(key_poll(key, next_tick()));
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 5) == 0)
                key = KeyW'($urandom_range(KeySide1, KeyF));
            if ($urandom_range(0, 9) == 0)
                ptt_lvl = ~ptt_lvl;
            p     = key_poll(key, next_tick());
            p.ptt = ptt_lvl;
            send(p);
        end
        if (ptt_lvl)
            send(key_poll(key, next_tick()));
        send(quiet_poll(next_tick()));
    endtask

    task automatic random_run();
        int    mode;
        t_poll p;
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
            press_run();
        end else if (mode == 7) begin
            repeat ($urandom_range(1, 4)) begin
                p      = noise_poll();
                p.ptt  = 1'b1;
                p.tick = next_tick();
                send(p);
            end
            p      = noise_poll();
            p.ptt  = 1'b0;
            p.tick = next_tick();
            send(p);
        end else if (mode == 8) begin
            send(noise_poll());
        end else begin
            p      = noise_poll();
            p.ptt  = 1'b0;
            p.tick = next_tick();
            send(p);
        end
    endtask

    initial begin
        t_poll            p;
        logic [TickW-1:0] settings [7];
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        cycles          = 0;
        sent            = 0;
        hold_sink       = 1'b0;
        now_t           = '0;
        settings        = '{32'd0, 32'd1, 32'd3, 32'hffff_ffff, 32'd8, 32'd40,
                            TickW'($urandom_range(2, 100))};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, long press threshold at its reset value
        send(quiet_poll(32'd100));
        p = key_poll(KeyMenu, 32'd200);
        p.ptt = 1'b1;
        send(p);                              // PTT pressed, scan skipped
        send(p);
        p.ptt = 1'b0;
        send(p);                              // PTT released, still no scan
        send(key_poll(KeyMenu, 32'd1000));    // menu pressed
        send(key_poll(KeyMenu, 32'd1499));
        p = key_poll(KeyMenu, 32'd1500);
        p.ptt = 1'b1;
        send(p);                              // threshold reached under PTT
        p.tick = 32'd1501;
        send(p);                              // long press of the kept key
        p.ptt = 1'b0;
        send(p);                              // PTT release, then long repeat
        send(key_poll(KeyMenu, 32'd1502));
        send(quiet_poll(32'd1503));           // release dropped after long press
        send(key_poll(KeyUp, 32'd2000));
        send(key_poll(KeyUp, 32'd2600));
        send(key_poll(KeyUp, 32'd2601));
        send(key_poll(KeyUp, 32'd2602));
        send(quiet_poll(32'd2603));           // up reports release after repeats
        send(key_poll(KeyF, 32'd3000));
        send(quiet_poll(32'd3001));
        send(key_poll(KeyFive, 32'd3002));    // F-shifted press
        send(quiet_poll(32'd3003));
        p = key_poll(KeyUp, 32'd3100);
        p.unstable[1] = 1'b1;                 // row 1 unsettled hides row 2
        send(p);
        p = key_poll(KeySide1, 32'd3101);
        p.unstable[0] = 1'b1;
        send(p);
        p = key_poll(KeySide2, 32'd3200);
        p.cols[3][0] = 1'b0;                  // side key wins over row 3
        send(p);
        send(quiet_poll(32'd3201));
        send(key_poll(KeyStar, 32'hffff_ff00));
        send(key_poll(KeyStar, 32'h0000_01f4)); // elapsed across tick wrap
        send(quiet_poll(32'h0000_01f5));

        for (int ph = 0; ph < 7; ph++) begin
            write_long_ticks(settings[ph]);
            if (ph == 2)
                hold_sink = 1'b1;
            sent = 0;
            while (sent < PhaseItems)
                random_run();
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
